// ----- sv/mwo_pkg.sv -----
`timescale 1ns / 1ps

package mwo_pkg;

   // Field widths
   localparam int FRAC_BITS      = 32;   // phase as a fraction of one cycle
   localparam int LEVEL_BITS     = 16;
   localparam int SAMPLE_BITS    = 16;
   localparam int SINE_ADDR_BITS = 10;
   localparam int Q15_BITS       = 15;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;

   // Quarter-wave sine ROM
   localparam int QTR_ADDR_BITS = SINE_ADDR_BITS - 2;
   localparam int QTR_SIZE      = 1 << QTR_ADDR_BITS;

   // Work word passed from front to back: level difference times this operand
   localparam int OPND_BITS = FRAC_BITS + 1;

   // Queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_SAW      = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_type;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVEFORM   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_HIGH = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_LOW  = CSR_INDEX_BITS'(3);

   typedef struct packed {
      wave_type                      waveform;
      logic [FRAC_BITS-1:0]          phase_step;
      logic signed [LEVEL_BITS-1:0]  level_high;
      logic signed [LEVEL_BITS-1:0]  level_low;
   } cfg_type;

   typedef struct packed {
      wave_type                      wave;
      logic signed [OPND_BITS-1:0]   opnd;
   } work_type;

   // Taylor series constants, Q30
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint          ONE_Q30     = 64'sd1073741824;

   // sin(m/QTR_SIZE * pi/2) in Q15, evaluated at elaboration only
   function automatic logic [Q15_BITS-1:0] quarter_sine(input int unsigned m);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = (longint'(m) * HALF_PI_Q30) >> QTR_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      // odd powers up to x^13; each term divides by (2n)(2n+1), signs alternate
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      if (sum < 0)
         sum = 0;
      if (sum > ONE_Q30)
         sum = ONE_Q30;
      return Q15_BITS'((sum * 32767 + ONE_Q30 / 2) >> 30);
   endfunction

   typedef logic [Q15_BITS-1:0] qtr_rom_type [QTR_SIZE];

   function automatic qtr_rom_type build_qtr_rom();
      qtr_rom_type rom;
      int          k;
      for (k = 0; k < QTR_SIZE; k++)
         rom[k] = quarter_sine(k);
      return rom;
   endfunction

   localparam qtr_rom_type          QTR_ROM   = build_qtr_rom();
   // value at the quarter point, just past the end of the ROM
   localparam logic [Q15_BITS-1:0]  SINE_PEAK = quarter_sine(QTR_SIZE);

endpackage

// ----- sv/multi_waveform_oscillator.sv -----
// Multi-waveform oscillator (sine, square, sawtooth, triangle).
// A request passes phase, classify, queue, multiply, offset, divide and clamp steps to rsp.
// Throughput: one word per cycle unless rsp_ready stalls; the phase multiplier, the classify
// stage and level multiplier are each one stage, with a 4-word queue between front and back.
// Reset (synchronous, active high) empties the pipeline and queue and loads the default
// registers: sine, zero step, full-scale high and low levels.
`timescale 1ns / 1ps

module multi_waveform_oscillator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [31:0]                            req_sample_index,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [mwo_pkg::SAMPLE_BITS-1:0]        rsp_sample_value,
   input  logic                                   csr_we,
   input  logic [mwo_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mwo_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import mwo_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      push;
   work_type  push_data;
   logic      pop;
   work_type  head;
   logic      full;
   logic      empty;

   // Register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WAVEFORM:   cfg_in.waveform   = wave_type'(csr_wdata[1:0]);
            CSR_PHASE_STEP: cfg_in.phase_step = csr_wdata[FRAC_BITS-1:0];
            CSR_LEVEL_HIGH: cfg_in.level_high = csr_wdata[LEVEL_BITS-1:0];
            CSR_LEVEL_LOW:  cfg_in.level_low  = csr_wdata[LEVEL_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.waveform   <= WAVE_SINE;
         cfg_ff.phase_step <= '0;
         cfg_ff.level_high <= {1'b0, {(LEVEL_BITS - 1){1'b1}}};
         cfg_ff.level_low  <= {1'b1, {(LEVEL_BITS - 1){1'b0}}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mwo_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg_i            (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_index (req_sample_index),
      .push_o           (push),
      .push_data_o      (push_data),
      .full_i           (full)
   );

   mwo_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (push),
      .push_data_i (push_data),
      .pop_i       (pop),
      .head_o      (head),
      .full_o      (full),
      .empty_o     (empty)
   );

   mwo_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg_i            (cfg_ff),
      .head_i           (head),
      .empty_i          (empty),
      .pop_o            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value)
   );

endmodule

// ----- sv/mwo_front.sv -----
`timescale 1ns / 1ps

module mwo_front (
   input  logic               clock,
   input  logic               reset,
   input  mwo_pkg::cfg_type   cfg_i,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_sample_index,
   output logic               push_o,
   output mwo_pkg::work_type  push_data_o,
   input  logic               full_i
);
   import mwo_pkg::*;

   localparam logic signed [OPND_BITS-1:0] TRI_MID = OPND_BITS'(1) << (FRAC_BITS - 1);

   logic                          f1_v_ff;
   logic [FRAC_BITS-1:0]          u_ff;
   logic [FRAC_BITS-1:0]          u_in;
   logic                          f2_v_ff;
   work_type                      f2_work_ff;
   work_type                      work_in;
   logic                          f2_load;
   logic [SINE_ADDR_BITS-1:0]     addr;
   logic [1:0]                    quad;
   logic [QTR_ADDR_BITS-1:0]      rem;
   logic [QTR_ADDR_BITS-1:0]      rom_idx;
   logic [Q15_BITS-1:0]           mag;
   logic signed [Q15_BITS:0]      sine_t;
   logic signed [LEVEL_BITS-1:0]  sq_level;
   logic signed [OPND_BITS-1:0]   u_ext;
   logic signed [OPND_BITS-1:0]   tri_v;

   // Stage handshake: the classify stage empties into the queue
   assign push_o      = f2_v_ff && !full_i;
   assign push_data_o = f2_work_ff;
   assign f2_load     = !f2_v_ff || push_o;
   assign req_ready   = !f1_v_ff || f2_load;

   // Phase: index times step, wrapping
   assign u_in = req_sample_index * cfg_i.phase_step;

   // Classify: sine lookup, square level, ramp and triangle operands
   always_comb begin
      addr    = u_ff[FRAC_BITS-1 -: SINE_ADDR_BITS];
      quad    = addr[SINE_ADDR_BITS-1 -: 2];
      rem     = addr[QTR_ADDR_BITS-1:0];
      rom_idx = quad[0] ? (~rem + 1'b1) : rem;
      if (quad[0] && (rem == '0))
         mag = SINE_PEAK;
      else
         mag = QTR_ROM[rom_idx];
      sine_t   = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      sq_level = u_ff[FRAC_BITS-1] ? cfg_i.level_low : cfg_i.level_high;
      u_ext    = $signed({1'b0, u_ff});

      // triangle: rises in the first quarter, falls through the middle half, rises in the last
      case (u_ff[FRAC_BITS-1 -: 2])
         2'b00:   tri_v = u_ext;
         2'b11:   tri_v = $signed({1'b1, u_ff});
         default: tri_v = TRI_MID - u_ext;
      endcase

      work_in.wave = cfg_i.waveform;
      case (cfg_i.waveform)
         WAVE_SINE:     work_in.opnd = OPND_BITS'(sine_t);
         WAVE_SQUARE:   work_in.opnd = OPND_BITS'(sq_level);
         WAVE_SAW:      work_in.opnd = u_ext;
         WAVE_TRIANGLE: work_in.opnd = tri_v;
         default:       work_in.opnd = '0;
      endcase
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         if (req_ready)
            f1_v_ff <= req_valid;
         if (f2_load)
            f2_v_ff <= f1_v_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (req_ready)
         u_ff <= u_in;
      if (f2_load)
         f2_work_ff <= work_in;
   end

   // a stalled work word waits in the classify stage
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      (f2_v_ff && full_i) |=> (f2_v_ff && $stable(f2_work_ff)))
      else $error("front: stalled work word lost or changed");

endmodule

// ----- sv/mwo_queue.sv -----
`timescale 1ns / 1ps

module mwo_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_i,
   input  mwo_pkg::work_type  push_data_i,
   input  logic               pop_i,
   output mwo_pkg::work_type  head_o,
   output logic               full_o,
   output logic               empty_o
);
   import mwo_pkg::*;

   localparam logic [QUEUE_PTR_BITS:0] COUNT_ONE  = (QUEUE_PTR_BITS + 1)'(1);
   localparam logic [QUEUE_PTR_BITS:0] COUNT_FULL = (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);

   work_type                   mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]  wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]  rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]    count_ff;
   logic [QUEUE_PTR_BITS:0]    count_in;

   assign head_o  = mem_ff[rd_ptr_ff];
   assign full_o  = (count_ff == COUNT_FULL);
   assign empty_o = (count_ff == '0);

   always_comb begin
      case ({push_i, pop_i})
         2'b10:   count_in = count_ff + COUNT_ONE;
         2'b01:   count_in = count_ff - COUNT_ONE;
         default: count_in = count_ff;
      endcase
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_i)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop_i)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push_i)
         mem_ff[wr_ptr_ff] <= push_data_i;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !full_o)
      else $error("queue: push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> !empty_o)
      else $error("queue: pop while empty");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push_i && !pop_i) |=> (count_ff == $past(count_ff) + COUNT_ONE))
      else $error("queue: fill level did not follow a lone push");

endmodule

// ----- sv/mwo_back.sv -----
`timescale 1ns / 1ps

module mwo_back (
   input  logic                          clock,
   input  logic                          reset,
   input  mwo_pkg::cfg_type              cfg_i,
   input  mwo_pkg::work_type             head_i,
   input  logic                          empty_i,
   output logic                          pop_o,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mwo_pkg::SAMPLE_BITS-1:0] rsp_sample_value
);
   import mwo_pkg::*;

   localparam int DIFF_BITS = LEVEL_BITS + 1;
   localparam int OFF_BITS  = LEVEL_BITS + 2;
   localparam int PROD_BITS = DIFF_BITS + OPND_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;
   localparam int VAL_BITS  = 35;
   localparam int QB        = 20;
   localparam int TRI_SHIFT = FRAC_BITS - 1;

   localparam logic signed [QB-1:0] SMAX = QB'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [QB-1:0] SMIN = -SMAX - QB'(1);
   localparam logic signed [QB-1:0] Q15_MAX = QB'((1 << Q15_BITS) - 1);
   localparam logic signed [QB-1:0] Q_ONE   = QB'(1);

   logic                          advance;
   // derived level terms, refreshed every cycle
   logic signed [DIFF_BITS-1:0]   d_ff;
   logic signed [OFF_BITS-1:0]    s1;
   logic signed [SUM_BITS-1:0]    sine_off_ff;
   logic signed [SUM_BITS-1:0]    tri_off_ff;
   // multiply stage
   logic                          b1_v_ff;
   wave_type                      b1_wave_ff;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic signed [LEVEL_BITS-1:0]  lvl_ff;
   // offset and scale stage
   logic                          b2_v_ff;
   logic                          b2_sine_ff;
   logic signed [VAL_BITS-1:0]    val_ff;
   logic signed [VAL_BITS-1:0]    val_in;
   logic signed [SUM_BITS-1:0]    sine_sum;
   logic signed [SUM_BITS-1:0]    tri_sum;
   // first divide step
   logic                          b3_v_ff;
   logic signed [QB-1:0]          q_ff;
   logic signed [QB-1:0]          q_in;
   logic signed [QB-1:0]          r_ff;
   logic signed [QB-1:0]          r_in;
   // last divide step and clamp
   logic signed [QB-1:0]          q1;
   logic signed [QB-1:0]          r2;
   logic signed [QB-1:0]          corr;
   logic signed [QB-1:0]          qf;
   logic signed [QB-1:0]          sat;
   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        rsp_value_ff;

   assign advance          = !rsp_valid_ff || rsp_ready;
   assign pop_o            = advance && !empty_i;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;

   assign s1 = OFF_BITS'(cfg_i.level_high) + OFF_BITS'(cfg_i.level_low) + OFF_BITS'(1);

   // Level difference and per-waveform offsets: (S+1)*32767 and (S+1)*2^30
   always_ff @(posedge clock) begin
      d_ff        <= DIFF_BITS'(cfg_i.level_high) - DIFF_BITS'(cfg_i.level_low);
      sine_off_ff <= (SUM_BITS'(s1) <<< Q15_BITS) - SUM_BITS'(s1);
      tri_off_ff  <= SUM_BITS'(s1) <<< (TRI_SHIFT - 1);
   end

   // Multiply by level difference
   assign prod_in = d_ff * head_i.opnd;

   // Offset and scale per waveform
   always_comb begin
      sine_sum = SUM_BITS'(prod_ff) + sine_off_ff;
      tri_sum  = SUM_BITS'(prod_ff) + tri_off_ff;
      case (b1_wave_ff)
         WAVE_SINE:     val_in = VAL_BITS'(sine_sum >>> 1);
         WAVE_SQUARE:   val_in = VAL_BITS'(lvl_ff);
         WAVE_SAW:      val_in = VAL_BITS'(prod_ff >>> FRAC_BITS) +
                                 VAL_BITS'(cfg_i.level_low);
         WAVE_TRIANGLE: val_in = VAL_BITS'(tri_sum >>> TRI_SHIFT);
         default:       val_in = '0;
      endcase
   end

   // Divide by 32767, first step: x = q0*2^15 + b gives x = q0*32767 + (q0 + b)
   always_comb begin
      if (b2_sine_ff) begin
         q_in = QB'(val_ff >>> Q15_BITS);
         r_in = $signed(QB'({1'b0, val_ff[Q15_BITS-1:0]})) + q_in;
      end else begin
         q_in = QB'(val_ff);
         r_in = '0;
      end
   end

   // Second step leaves a remainder within a few counts of 0..32766
   always_comb begin
      q1 = r_ff >>> Q15_BITS;
      r2 = $signed(QB'({1'b0, r_ff[Q15_BITS-1:0]})) + q1;
      if (r2 < 0)
         corr = -Q_ONE;
      else if (r2 >= Q15_MAX)
         corr = Q_ONE;
      else
         corr = '0;
      qf = q_ff + q1 + corr;
      if (qf > SMAX)
         sat = SMAX;
      else if (qf < SMIN)
         sat = SMIN;
      else
         sat = qf;
   end

   // Valid bits: the whole back end moves together
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff      <= 1'b0;
         b2_v_ff      <= 1'b0;
         b3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_v_ff      <= pop_o;
         b2_v_ff      <= b1_v_ff;
         b3_v_ff      <= b2_v_ff;
         rsp_valid_ff <= b3_v_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (advance) begin
         b1_wave_ff   <= head_i.wave;
         prod_ff      <= prod_in;
         lvl_ff       <= head_i.opnd[LEVEL_BITS-1:0];
         b2_sine_ff   <= (b1_wave_ff == WAVE_SINE);
         val_ff       <= val_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         rsp_value_ff <= sat[SAMPLE_BITS-1:0];
      end
   end

   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(b3_v_ff))
      else $error("back: result word appeared without a word in the last stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable({b1_v_ff, b2_v_ff, b3_v_ff}))
      else $error("back: pipeline moved while the output was stalled");

endmodule
